// ===== rtl/ddo_pkg.sv =====
// shared constants, types and the arctangent lookup function of the odometry integrator
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int POSITION_BITS = 32;

  localparam int CORD_IDX_W = 5;
  localparam int CORD_W     = 34;
  localparam int ANG_W      = 33;
  localparam int Q14_W      = 16;
  localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [CORD_W-1:0] Q14_ROUND    = 34'sd32768;

  localparam logic [31:0] HEAD_SCALE = 32'd2867080551;

  localparam int DIV_N_W     = 54;
  localparam int DIV_D_W     = 17;
  localparam int DIV_STEPS   = DIV_N_W / 2;
  localparam int DIV_CNT_W   = 5;
  localparam logic [DIV_D_W-1:0] DIV_D = 17'd125000;
  localparam logic [63:0] ROUND_ADD     = 64'd32000000;
  localparam logic [63:0] ROUND_ADD_NEG = 64'd32000001;

  localparam int SUM_W = 57;

  localparam int IN_W  = 64;
  localparam int OUT_W = 192;

  typedef struct packed {
    logic load;
    logic trig;
    logic mulp;
    logic div_start;
    logic acc;
    logic out_load;
  } ddo_cmd_t;

  typedef struct packed {
    logic cord_done;
    logic div_done;
    logic out_free;
  } ddo_status_t;

  function automatic logic [ANG_W-1:0] atan_lut(input logic [CORD_IDX_W-1:0] idx);
    logic [ANG_W-1:0] r;
    case (idx)
      5'd0:    r = 33'd536870912;
      5'd1:    r = 33'd316933406;
      5'd2:    r = 33'd167458907;
      5'd3:    r = 33'd85004756;
      5'd4:    r = 33'd42667331;
      5'd5:    r = 33'd21354465;
      5'd6:    r = 33'd10679838;
      5'd7:    r = 33'd5340245;
      5'd8:    r = 33'd2670163;
      5'd9:    r = 33'd1335087;
      5'd10:   r = 33'd667544;
      5'd11:   r = 33'd333772;
      5'd12:   r = 33'd166886;
      5'd13:   r = 33'd83443;
      5'd14:   r = 33'd41722;
      5'd15:   r = 33'd20861;
      5'd16:   r = 33'd10430;
      5'd17:   r = 33'd5215;
      5'd18:   r = 33'd2608;
      5'd19:   r = 33'd1304;
      5'd20:   r = 33'd652;
      5'd21:   r = 33'd326;
      5'd22:   r = 33'd163;
      5'd23:   r = 33'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/diff_drive_odometry_integrator.sv =====
// top level of the dead reckoning odometry integrator
// steps: first cordic pass, trig, products, dividers with the second pass, accumulate, output
// a new word is taken only after the last one is loaded to the output; the cordic is shared
// each divider retires two quotient bits a cycle; the second cordic pass runs beside them
// reset clears pose, heading, counter and timestamp state; the first word integrates no time
`timescale 1ns / 1ps
module diff_drive_odometry_integrator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // linear_velocity, angular_velocity, timestamp_us
  input  logic [ddo_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // sequence_number, position_x, position_y, heading_angle, quaternion_z,
  // quaternion_w, echo_linear, echo_angular
  output logic [ddo_pkg::OUT_W-1:0] m_axis_tdata
);

  ddo_pkg::ddo_cmd_t    cmd;
  ddo_pkg::ddo_status_t status;

  ddo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddo_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/ddo_cordic.sv =====
// iterative rotation cordic giving q1.14 sine and cosine of a binary angle
`timescale 1ns / 1ps
module ddo_cordic (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [31:0]                     angle_i,
  output logic signed [ddo_pkg::Q14_W-1:0] sin_o,
  output logic signed [ddo_pkg::Q14_W-1:0] cos_o,
  output logic                            done_o
);

  logic signed [ddo_pkg::CORD_W-1:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [ddo_pkg::ANG_W-1:0]  z_q, z_d, at;
  logic [1:0]                        quad_q, quad_d;
  logic [ddo_pkg::CORD_IDX_W-1:0]    idx_q, idx_d;
  logic                              busy_q, busy_d;
  logic signed [ddo_pkg::Q14_W-1:0]  rs, rc;

  function automatic logic signed [ddo_pkg::Q14_W-1:0] to_q14(
    input logic signed [ddo_pkg::CORD_W-1:0] v
  );
    logic signed [ddo_pkg::CORD_W-1:0] t;
    logic signed [ddo_pkg::Q14_W-1:0]  r;
    t = (v + ddo_pkg::Q14_ROUND) >>> 16;
    if (t > ddo_pkg::CORD_W'(16384)) begin
      r = 16'sd16384;
    end else if (t < -ddo_pkg::CORD_W'(16384)) begin
      r = -16'sd16384;
    end else begin
      r = t[ddo_pkg::Q14_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    dx     = y_q >>> idx_q;
    dy     = x_q >>> idx_q;
    at     = $signed(ddo_pkg::atan_lut(idx_q));
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (start_i) begin
      x_d    = ddo_pkg::CORDIC_START;
      y_d    = '0;
      z_d    = $signed({3'b000, angle_i[29:0]});
      quad_d = angle_i[31:30];
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!z_q[ddo_pkg::ANG_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      if (idx_q == ddo_pkg::CORD_IDX_W'(ddo_pkg::CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_comb begin
    rs = to_q14(y_q);
    rc = to_q14(x_q);
    case (quad_q)
      2'd0: begin
        sin_o = rs;
        cos_o = rc;
      end
      2'd1: begin
        sin_o = rc;
        cos_o = -rs;
      end
      2'd2: begin
        sin_o = -rs;
        cos_o = -rc;
      end
      default: begin
        sin_o = -rc;
        cos_o = rs;
      end
    endcase
  end

  assign done_o = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

endmodule

// ===== rtl/ddo_div.sv =====
// radix-4 restoring divider by the fixed position scale
`timescale 1ns / 1ps
module ddo_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ddo_pkg::DIV_N_W-1:0] dividend_i,
  output logic [ddo_pkg::DIV_N_W-1:0] quotient_o,
  output logic                        done_o
);

  logic [ddo_pkg::DIV_N_W-1:0]   n_q, n_d;
  logic [ddo_pkg::DIV_D_W-1:0]   r_q, r_d;
  logic [ddo_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic [ddo_pkg::DIV_D_W:0]     r1, r1s, r2, r2s;
  logic                          ge1, ge2;

  always_comb begin
    r1  = {r_q, n_q[ddo_pkg::DIV_N_W-1]};
    ge1 = r1 >= {1'b0, ddo_pkg::DIV_D};
    r1s = ge1 ? r1 - {1'b0, ddo_pkg::DIV_D} : r1;
    r2  = {r1s[ddo_pkg::DIV_D_W-1:0], n_q[ddo_pkg::DIV_N_W-2]};
    ge2 = r2 >= {1'b0, ddo_pkg::DIV_D};
    r2s = ge2 ? r2 - {1'b0, ddo_pkg::DIV_D} : r2;
    n_d    = n_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      n_d    = dividend_i;
      r_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[ddo_pkg::DIV_N_W-3:0], ge1, ge2};
      r_d = r2s[ddo_pkg::DIV_D_W-1:0];
      if (cnt_q == ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  assign quotient_o = n_q;
  assign done_o     = !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
  end

endmodule

// ===== rtl/ddo_datapath.sv =====
// pose state, multipliers, dividers, cordic and output word register
`timescale 1ns / 1ps
module ddo_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ddo_pkg::IN_W-1:0]  in_data_i,
  input  ddo_pkg::ddo_cmd_t         cmd_i,
  input  logic                      out_ready_i,
  output ddo_pkg::ddo_status_t      status_o,
  output logic                      out_valid_o,
  output logic [ddo_pkg::OUT_W-1:0] out_data_o
);

  localparam int PB = ddo_pkg::POSITION_BITS;
  localparam logic signed [ddo_pkg::SUM_W-1:0] PMAX = ddo_pkg::SUM_W'((64'sd1 <<< (PB - 1)) - 1);
  localparam logic signed [ddo_pkg::SUM_W-1:0] PMIN = -PMAX - 1;
  localparam logic signed [ddo_pkg::SUM_W-1:0] OMAX = ddo_pkg::SUM_W'(64'sd2147483647);
  localparam logic signed [ddo_pkg::SUM_W-1:0] OMIN = -OMAX - 1;

  logic signed [15:0] v_q, w_q, cos_q, sin_q;
  logic [31:0]        dt_q, prev_q, heading_q, count_q, p1_q, ts, heading_d;
  logic               started_q, negx_q, negy_q, out_valid_q;
  logic signed [48:0] m_q, wdt_q;
  logic [63:0]        a64, p0_q;
  logic signed [64:0] pxf, pyf;
  logic signed [63:0] px_q, py_q;
  logic [63:0]        sumx, sumy;
  logic [ddo_pkg::DIV_N_W-1:0] qx, qy;
  logic               divx_done, divy_done, cord_done;
  logic signed [ddo_pkg::Q14_W-1:0] c_sin, c_cos;
  logic signed [PB-1:0]             accx_q, accy_q;
  logic signed [ddo_pkg::SUM_W-1:0] stepx, stepy, sx, sy, accx_w, accy_w, ox, oy;
  logic [31:0]        cord_angle;
  logic [ddo_pkg::OUT_W-1:0] out_q;

  assign ts = in_data_i[63:32];

  assign cord_angle = cmd_i.load ? heading_q : {1'b0, heading_q[31:1]};

  ddo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load | cmd_i.div_start),
    .angle_i (cord_angle),
    .sin_o   (c_sin),
    .cos_o   (c_cos),
    .done_o  (cord_done)
  );

  always_comb begin
    sumx = px_q[63] ? ~px_q + ddo_pkg::ROUND_ADD_NEG : px_q + ddo_pkg::ROUND_ADD;
    sumy = py_q[63] ? ~py_q + ddo_pkg::ROUND_ADD_NEG : py_q + ddo_pkg::ROUND_ADD;
  end

  ddo_div u_divx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sumx[62:9]),
    .quotient_o (qx),
    .done_o     (divx_done)
  );

  ddo_div u_divy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sumy[62:9]),
    .quotient_o (qy),
    .done_o     (divy_done)
  );

  always_comb begin
    a64       = {{15{wdt_q[48]}}, wdt_q};
    heading_d = p1_q + p0_q[63:32] + {31'b0, p0_q[31]};
    pxf       = m_q * cos_q;
    pyf       = m_q * sin_q;
    stepx     = negx_q ? -$signed({3'b000, qx}) : $signed({3'b000, qx});
    stepy     = negy_q ? -$signed({3'b000, qy}) : $signed({3'b000, qy});
    sx        = ddo_pkg::SUM_W'(accx_q) + stepx;
    sy        = ddo_pkg::SUM_W'(accy_q) + stepy;
    accx_w    = ddo_pkg::SUM_W'(accx_q);
    accy_w    = ddo_pkg::SUM_W'(accy_q);
    ox        = accx_w > OMAX ? OMAX : (accx_w < OMIN ? OMIN : accx_w);
    oy        = accy_w > OMAX ? OMAX : (accy_w < OMIN ? OMIN : accy_w);
  end

  assign status_o.cord_done = cord_done;
  assign status_o.div_done  = divx_done & divy_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      prev_q      <= '0;
      heading_q   <= '0;
      count_q     <= '0;
      accx_q      <= '0;
      accy_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        started_q <= 1'b1;
        prev_q    <= ts;
      end
      if (cmd_i.mulp) begin
        heading_q <= heading_d;
      end
      if (cmd_i.acc) begin
        accx_q <= sx > PMAX ? PMAX[PB-1:0] : (sx < PMIN ? PMIN[PB-1:0] : sx[PB-1:0]);
        accy_q <= sy > PMAX ? PMAX[PB-1:0] : (sy < PMIN ? PMIN[PB-1:0] : sy[PB-1:0]);
      end
      if (cmd_i.out_load) begin
        count_q     <= count_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q  <= $signed(in_data_i[15:0]);
      w_q  <= $signed(in_data_i[31:16]);
      dt_q <= started_q ? ts - prev_q : '0;
    end
    m_q   <= v_q * $signed({1'b0, dt_q});
    wdt_q <= w_q * $signed({1'b0, dt_q});
    p0_q  <= a64[31:0] * ddo_pkg::HEAD_SCALE;
    p1_q  <= a64[63:32] * ddo_pkg::HEAD_SCALE;
    if (cmd_i.trig) begin
      cos_q <= c_cos;
      sin_q <= c_sin;
    end
    if (cmd_i.mulp) begin
      px_q <= pxf[63:0];
      py_q <= pyf[63:0];
    end
    if (cmd_i.div_start) begin
      negx_q <= px_q[63];
      negy_q <= py_q[63];
    end
    if (cmd_i.out_load) begin
      out_q <= {w_q, v_q, c_cos, c_sin, heading_q, oy[31:0], ox[31:0], count_q};
    end
  end

endmodule

// ===== rtl/ddo_ctrl.sv =====
// sequencing state machine of the odometry integrator
`timescale 1ns / 1ps
module ddo_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ddo_pkg::ddo_status_t status_i,
  output ddo_pkg::ddo_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORD = 3'd1;
  localparam logic [2:0] S_TRIG = 3'd2;
  localparam logic [2:0] S_MULP = 3'd3;
  localparam logic [2:0] S_DIVI = 3'd4;
  localparam logic [2:0] S_RUN  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CORD;
        end
      end
      S_CORD: begin
        if (status_i.cord_done) begin
          state_d = S_TRIG;
        end
      end
      S_TRIG: begin
        cmd_o.trig = 1'b1;
        state_d    = S_MULP;
      end
      S_MULP: begin
        cmd_o.mulp = 1'b1;
        state_d    = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_RUN;
      end
      S_RUN: begin
        if (status_i.div_done && status_i.cord_done) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ddo_checker.sv =====
// port level checks of the odometry integrator and their binding
`timescale 1ns / 1ps
module ddo_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ddo_pkg::OUT_W-1:0] m_axis_tdata
);

  logic [31:0] last_seq_q;
  logic        seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_seq_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      seen_q     <= 1'b1;
      last_seq_q <= m_axis_tdata[31:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && seen_q |-> m_axis_tdata[31:0] == last_seq_q + 32'd1)
    else $error("sequence number skipped");

endmodule

bind diff_drive_odometry_integrator ddo_checker u_ddo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/diff_drive_odometry_integrator_test.sv =====
// self-checking testbench for the dead reckoning odometry integrator
`timescale 1ns / 1ps
module diff_drive_odometry_integrator_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic [31:0] ts;
    logic signed [15:0] w;
    logic signed [15:0] v;
  } command_t;

  typedef struct {
    command_t cmd;
    int       phase;
  } pending_t;

  typedef struct packed {
    logic [15:0] echo_w;
    logic [15:0] echo_v;
    logic [15:0] qw;
    logic [15:0] qz;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic [31:0] seq;
  } pose_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [ddo_pkg::IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [ddo_pkg::OUT_W-1:0] m_axis_tdata;

  diff_drive_odometry_integrator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  pending_t pending_cmds[$];
  pose_t    pose_expected[$];
  int       cur_phase, errors, idle_cycles;
  bit       stim_done;

  longint      odo_x, odo_y;
  logic [31:0] odo_heading, odo_count, odo_last_ts;
  bit          odo_started;

  int send_idle_pct[4] = '{0, 46, 0, 19};
  int recv_idle_pct[4] = '{0, 0, 46, 19};

  function automatic longint round_q14(longint val);
    longint r;
    r = (val + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic longint atan_table(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic void rotate_angle(input logic [31:0] ang, output longint sn,
                                       output longint cs);
    longint x, y, z, dx, dy, rs, rc;
    x = 652032874;
    y = 0;
    z = longint'(ang[29:0]);
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_table(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_table(i));
      end
    end
    rs = round_q14(y);
    rc = round_q14(x);
    case (ang[31:30])
      2'd0: begin sn = rs;  cs = rc;  end
      2'd1: begin sn = rc;  cs = -rs; end
      2'd2: begin sn = -rs; cs = -rc; end
      default: begin sn = -rc; cs = rs; end
    endcase
  endfunction

  function automatic longint travel_step(longint travel, longint trig);
    longint p, mag, q;
    p = travel * trig;
    mag = (p < 0) ? -p : p;
    q = (mag + 32000000) / 64000000;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint clamp_bits(longint val, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (val > hi) return hi;
    if (val < lo) return lo;
    return val;
  endfunction

  function automatic pose_t integrate_command(command_t cmd);
    pose_t r;
    logic [31:0] dt;
    longint sn, cs, travel;
    logic [63:0] hp;
    if (!odo_started) begin
      odo_last_ts = cmd.ts;
      odo_started = 1;
    end
    dt = cmd.ts - odo_last_ts;
    rotate_angle(odo_heading, sn, cs);
    travel = longint'(cmd.v) * longint'({32'd0, dt});
    odo_x = clamp_bits(odo_x + travel_step(travel, cs), ddo_pkg::POSITION_BITS);
    odo_y = clamp_bits(odo_y + travel_step(travel, sn), ddo_pkg::POSITION_BITS);
    hp = 64'(longint'(cmd.w) * longint'({32'd0, dt})) * 64'd2867080551;
    odo_heading = 32'((hp + 64'h8000_0000) >> 32);
    rotate_angle(odo_heading >> 1, sn, cs);
    r.seq     = odo_count;
    r.pos_x   = 32'(clamp_bits(odo_x, 32));
    r.pos_y   = 32'(clamp_bits(odo_y, 32));
    r.heading = odo_heading;
    r.qz      = 16'(sn);
    r.qw      = 16'(cs);
    r.echo_v  = cmd.v;
    r.echo_w  = cmd.w;
    odo_count   = odo_count + 1;
    odo_last_ts = cmd.ts;
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pose_expected.push_back(integrate_command(command_t'(s_axis_tdata)));
      end
      if ((!s_axis_tvalid || s_axis_tready) && pending_cmds.size() > 0) begin
        cur_phase = pending_cmds[0].phase;
        if ($urandom_range(99) >= send_idle_pct[cur_phase]) begin
          s_axis_tdata  <= pending_cmds[0].cmd;
          s_axis_tvalid <= 1;
          pending_cmds.delete(0);
        end else begin
          s_axis_tvalid <= 0;
        end
      end else if (!s_axis_tvalid || s_axis_tready) begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    pose_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 0;
      idle_cycles   <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct[cur_phase]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = pose_t'(m_axis_tdata);
        if (pose_expected.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = pose_expected.pop_front();
          if (got.seq !== want.seq || got.pos_x !== want.pos_x ||
              got.pos_y !== want.pos_y || got.heading !== want.heading ||
              got.qz !== want.qz || got.qw !== want.qw ||
              got.echo_v !== want.echo_v || got.echo_w !== want.echo_w) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[diff_drive_odometry_integrator] ERROR");
        $finish;
      end
    end
  end

  task automatic queue_cmd(logic [15:0] v, logic [15:0] w, logic [31:0] ts, int ph);
    pending_t p;
    p.cmd.v = v;
    p.cmd.w = w;
    p.cmd.ts = ts;
    p.phase = ph;
    pending_cmds.push_back(p);
  endtask

  initial begin
    logic [31:0] ts;
    int ph;
    errors = 0;
    cur_phase = 0;
    odo_x = 0; odo_y = 0; odo_heading = 0; odo_count = 0; odo_last_ts = 0;
    odo_started = 0;
    rst_ni = 0;
    // directed: first command, extremes, backwards time, saturation
    queue_cmd(16'h7fff, 16'h7fff, 32'hdead_beef, 0);
    queue_cmd(16'h0100, 16'h0000, 32'hdead_beef + 1000000, 0);
    queue_cmd(16'h8000, 16'h8000, 32'hdead_beef + 1100000, 0);
    queue_cmd(16'h0400, 16'h0648, 32'hdead_beef + 2100000, 0);
    queue_cmd(16'h0400, 16'h0648, 32'hdead_beef + 3100000, 0);
    queue_cmd(16'h0400, 16'hf9b8, 32'hdead_beef + 3600000, 0);
    queue_cmd(16'h0000, 16'h0000, 32'h0000_0000, 0);
    queue_cmd(16'h7fff, 16'h0000, 32'hffff_ffff, 0);
    queue_cmd(16'h7fff, 16'h0000, 32'h7fff_ffff, 0);
    queue_cmd(16'h8000, 16'h7fff, 32'h0000_0010, 0);
    queue_cmd(16'h8000, 16'h0000, 32'hf000_0000, 0);
    queue_cmd(16'h8000, 16'h0000, 32'he000_0000, 0);
    queue_cmd(16'h8000, 16'h0000, 32'hd000_0000, 0);
    queue_cmd(16'hffff, 16'hffff, 32'hd000_0001, 0);
    queue_cmd(16'h0001, 16'h0001, 32'h5555_5555, 0);
    queue_cmd(16'h5555, 16'haaaa, 32'haaaa_aaaa, 0);
    ts = 32'haaaa_aaaa;
    for (int i = 0; i < 600; i++) begin
      ph = i / 150;
      if ($urandom_range(9) == 0) begin
        ts = $urandom;
        queue_cmd(16'($urandom), 16'($urandom), ts, ph);
      end else begin
        ts = ts + $urandom_range(200000, 1);
        queue_cmd(16'($urandom_range(8192) - 4096), 16'($urandom), ts, ph);
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    while (pending_cmds.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (pose_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[diff_drive_odometry_integrator] OK");
    end else begin
      $display("[diff_drive_odometry_integrator] ERROR");
    end
    $finish;
  end

endmodule
